[rtl/olis_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olis_pkg: shared types and constants of the ordered list store
// Operation codes, result status codes, queue entry and result records.
// ----------------------------------------------------------------------------
package olis_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned KindW        = 3;
  localparam int unsigned ValW         = 32;
  localparam int unsigned PosW         = 7;
  localparam int unsigned QDepth       = 2;
  localparam int unsigned QPtrW        = $clog2(QDepth);
  localparam int unsigned QCntW        = $clog2(QDepth + 1);

  typedef enum logic [KindW-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_POP    = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SEARCH = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    op_e                   op;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]       pos;
  } op_t;

  typedef struct packed {
    status_e               status;
    logic [PosW-1:0]       fpos;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]       count;
    logic                  last;
  } res_t;

endpackage
`default_nettype wire

[rtl/olis_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olis_front: input stage of the ordered list store
// Accepts input beats, decodes the operation and drops unused kind codes.
// ----------------------------------------------------------------------------
module olis_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [olis_pkg::KindW-1:0]      kind_i,
  input  wire logic signed [olis_pkg::ValW-1:0] item_value_i,
  input  wire logic [olis_pkg::PosW-1:0]       position_i,
  output logic                                 q_valid_o,
  input  wire logic                            q_ready_i,
  output olis_pkg::op_t                        q_op_o
);

  logic          vld_q, vld_d;
  olis_pkg::op_t op_q, op_d;
  logic          accept;
  logic          kind_ok;

  assign in_ready_o = !vld_q || q_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign kind_ok    = kind_i <= olis_pkg::KindW'(olis_pkg::OP_READ);

  always_comb begin
    vld_d = vld_q;
    op_d  = op_q;
    if (vld_q && q_ready_i) begin
      vld_d = 1'b0;
    end
    if (accept && kind_ok) begin
      vld_d       = 1'b1;
      op_d.op     = olis_pkg::op_e'(kind_i);
      op_d.value  = item_value_i;
      op_d.pos    = position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign q_valid_o = vld_q;
  assign q_op_o    = op_q;

endmodule
`default_nettype wire

[rtl/olis_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olis_queue: short operation queue between front and back end
// Two-entry FIFO of decoded operations.
// ----------------------------------------------------------------------------
module olis_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire olis_pkg::op_t wr_op_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output olis_pkg::op_t      rd_op_o
);

  olis_pkg::op_t                  mem_q [olis_pkg::QDepth];
  logic [olis_pkg::QPtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [olis_pkg::QCntW-1:0]     cnt_q, cnt_d;
  logic                           push, pop;

  assign wr_ready_o = cnt_q != olis_pkg::QCntW'(olis_pkg::QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_op_o    = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule
`default_nettype wire

[rtl/olis_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olis_back: execution end of the ordered list store
// Holds the element shift line, executes operations and scans for results.
// ----------------------------------------------------------------------------
module olis_back #(
  parameter int unsigned DEPTH = olis_pkg::DepthDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output logic               q_ready_o,
  input  wire olis_pkg::op_t q_op_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output olis_pkg::res_t     res_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic signed [olis_pkg::ValW-1:0] store_q [DEPTH];
  logic signed [olis_pkg::ValW-1:0] store_d [DEPTH];
  logic signed [olis_pkg::ValW-1:0] prev_w  [DEPTH];
  logic signed [olis_pkg::ValW-1:0] next_w  [DEPTH];

  logic                  state_q, state_d;
  logic                  read_mode_q, read_mode_d;
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic [DEPTH-1:0]      mask_q, mask_d, match_w;
  logic                  out_vld_q, out_vld_d;
  olis_pkg::res_t        res_q, res_d;

  logic                  slot_free, fire, full, empty, ins_ok, rem_ok;
  logic [olis_pkg::PosW-1:0] cnt7, pm1, ins_at, rem_at, idx_pos;
  logic [CW-1:0]         nm1;
  logic                  do_ins, do_rem, do_rot;
  logic                  emit;
  olis_pkg::status_e     emit_status;
  logic                  scan_last;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_nbr
      if (g == 0) begin : g_first
        assign prev_w[g] = store_q[0];
      end else begin : g_rest
        assign prev_w[g] = store_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_lastn
        assign next_w[g] = store_q[0];
      end else begin : g_restn
        assign next_w[g] = store_q[g+1];
      end
      assign match_w[g] = (CW'(g) < count_q) && (store_q[g] == q_op_i.value);
    end
  endgenerate

  assign slot_free = !out_vld_q || out_ready_i;
  assign q_ready_o = (state_q == StIdle) && slot_free;
  assign fire      = q_valid_i && q_ready_o;
  assign full      = count_q == CW'(DEPTH);
  assign empty     = count_q == '0;
  assign cnt7      = olis_pkg::PosW'(count_q);
  assign pm1       = q_op_i.pos - 1'b1;
  assign ins_ok    = (q_op_i.pos != '0) && (q_op_i.pos <= cnt7 + 1'b1);
  assign rem_ok    = (q_op_i.pos != '0) && (q_op_i.pos <= cnt7);
  assign nm1       = count_q - 1'b1;
  assign idx_pos   = olis_pkg::PosW'(idx_q) + 1'b1;

  always_comb begin
    state_d     = state_q;
    read_mode_d = read_mode_q;
    count_d     = count_q;
    idx_d       = idx_q;
    mask_d      = mask_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    res_d       = res_q;
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    do_rot      = 1'b0;
    ins_at      = pm1;
    rem_at      = pm1;
    emit        = 1'b0;
    emit_status = olis_pkg::ST_OK;
    scan_last   = 1'b0;

    if (state_q == StIdle) begin
      if (fire) begin
        case (q_op_i.op)
          olis_pkg::OP_APPEND: begin
            emit = 1'b1;
            if (full) begin
              emit_status = olis_pkg::ST_FULL;
            end else begin
              do_ins  = 1'b1;
              ins_at  = cnt7;
              count_d = count_q + 1'b1;
            end
          end
          olis_pkg::OP_INSERT: begin
            emit = 1'b1;
            if (!ins_ok) begin
              emit_status = olis_pkg::ST_BADPOS;
            end else if (full) begin
              emit_status = olis_pkg::ST_FULL;
            end else begin
              do_ins  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          olis_pkg::OP_POP: begin
            emit = 1'b1;
            if (empty) begin
              emit_status = olis_pkg::ST_EMPTY;
            end else begin
              count_d = count_q - 1'b1;
            end
          end
          olis_pkg::OP_REMOVE: begin
            emit = 1'b1;
            if (empty) begin
              emit_status = olis_pkg::ST_EMPTY;
            end else if (!rem_ok) begin
              emit_status = olis_pkg::ST_BADPOS;
            end else begin
              do_rem  = 1'b1;
              count_d = count_q - 1'b1;
            end
          end
          olis_pkg::OP_SEARCH: begin
            if (empty) begin
              emit        = 1'b1;
              emit_status = olis_pkg::ST_EMPTY;
            end else if (match_w == '0) begin
              emit        = 1'b1;
              emit_status = olis_pkg::ST_NOTFOUND;
            end else begin
              state_d     = StScan;
              read_mode_d = 1'b0;
              mask_d      = match_w;
              idx_d       = '0;
            end
          end
          olis_pkg::OP_READ: begin
            if (empty) begin
              emit        = 1'b1;
              emit_status = olis_pkg::ST_EMPTY;
            end else begin
              state_d     = StScan;
              read_mode_d = 1'b1;
              idx_d       = '0;
            end
          end
          default: begin
          end
        endcase
        if (emit) begin
          out_vld_d    = 1'b1;
          res_d.status = emit_status;
          res_d.fpos   = '0;
          res_d.value  = '0;
          res_d.count  = olis_pkg::PosW'(count_d);
          res_d.last   = 1'b1;
        end
      end
    end else begin
      if (read_mode_q) begin
        // rotate the live elements so the next one sits at the head
        if (slot_free) begin
          scan_last    = CW'(idx_q) == nm1;
          do_rot       = 1'b1;
          out_vld_d    = 1'b1;
          res_d.status = olis_pkg::ST_OK;
          res_d.fpos   = idx_pos;
          res_d.value  = store_q[0];
          res_d.count  = cnt7;
          res_d.last   = scan_last;
          idx_d        = idx_q + 1'b1;
          if (scan_last) begin
            state_d = StIdle;
          end
        end
      end else begin
        scan_last = mask_q[DEPTH-1:1] == '0;
        if (!mask_q[0]) begin
          mask_d = mask_q >> 1;
          idx_d  = idx_q + 1'b1;
        end else if (slot_free) begin
          out_vld_d    = 1'b1;
          res_d.status = olis_pkg::ST_OK;
          res_d.fpos   = idx_pos;
          res_d.value  = '0;
          res_d.count  = cnt7;
          res_d.last   = scan_last;
          mask_d       = mask_q >> 1;
          idx_d        = idx_q + 1'b1;
          if (scan_last) begin
            state_d = StIdle;
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      store_d[i] = store_q[i];
      if (do_ins) begin
        if (i == int'(ins_at)) begin
          store_d[i] = q_op_i.value;
        end else if (i > int'(ins_at)) begin
          store_d[i] = prev_w[i];
        end
      end else if (do_rem) begin
        if (i >= int'(rem_at)) begin
          store_d[i] = next_w[i];
        end
      end else if (do_rot) begin
        if (i == int'(nm1)) begin
          store_d[i] = store_q[0];
        end else begin
          store_d[i] = next_w[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      read_mode_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      read_mode_q <= read_mode_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    for (int i = 0; i < DEPTH; i++) begin
      store_q[i] <= store_d[i];
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count above capacity");

  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (count_q != '0))
    else $error("scan running on an empty list");

  a_search_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && !read_mode_q) |-> (mask_q != '0))
    else $error("search scan with no pending match");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan && slot_free && scan_last && (read_mode_q || mask_q[0]))
      |=> (state_q == StIdle && out_vld_q && res_q.last))
    else $error("scan did not close on its final beat");

  a_count_scan_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |=> $stable(count_q))
    else $error("count changed during a scan");

endmodule
`default_nettype wire

[rtl/ordered_list_insert_delete_search.sv]
`default_nettype none
// An input beat passes the front register and the queue to the back end, whose result
// register drives the output; search and read-all first enter a scan state, where a
// search steps over each slot holding no match. Throughput, with no output stall: one
// item per cycle for append, insert and remove; read-all and search hold the back end
// until their last result beat is issued. Reset clears the element count, the queue and all
// handshake state; element contents stay undefined until written.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_search: ordered list store
// Front stage decodes operations into a short queue; the back end executes them
// on a shift line of elements and returns one or more result beats per operation it executes.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_search #(
  parameter int unsigned DEPTH = olis_pkg::DepthDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [olis_pkg::KindW-1:0]        kind_i,
  input  wire logic signed [olis_pkg::ValW-1:0]  item_value_i,
  input  wire logic [olis_pkg::PosW-1:0]         position_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [2:0]                             status_o,
  output logic [olis_pkg::PosW-1:0]              found_position_o,
  output logic signed [olis_pkg::ValW-1:0]       element_value_o,
  output logic [olis_pkg::PosW-1:0]              element_count_o,
  output logic                                   last_result_o
);

  logic           fq_valid, fq_ready;
  olis_pkg::op_t  fq_op;
  logic           qb_valid, qb_ready;
  olis_pkg::op_t  qb_op;
  olis_pkg::res_t res;

  olis_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .position_i   (position_i),
    .q_valid_o    (fq_valid),
    .q_ready_i    (fq_ready),
    .q_op_o       (fq_op)
  );

  olis_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_op_i    (fq_op),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_op_o    (qb_op)
  );

  olis_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_op_i      (qb_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign status_o         = res.status;
  assign found_position_o = res.fpos;
  assign element_value_o  = res.value;
  assign element_count_o  = res.count;
  assign last_result_o    = res.last;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ordered list store
// Drives list operations through the valid/ready input channel, mirrors the
// element list in a scoreboard and compares every result beat in order.
// Directed corner cases come first (empty list, bad positions, value extremes,
// unused operation codes), then random grow/shrink traffic that fills and
// empties the store repeatedly, under several idle and stall mixes.
// ----------------------------------------------------------------------------

class list_scoreboard;
  logic signed [olis_pkg::ValW-1:0] store [olis_pkg::DepthDefault];
  int unsigned                      count;
  olis_pkg::res_t                   expected_q [$];
  int unsigned                      mismatches;

  function void queue_result(olis_pkg::status_e st, int unsigned fpos,
                             logic signed [olis_pkg::ValW-1:0] v, bit last);
    olis_pkg::res_t r;
    r.status = st;
    r.fpos   = olis_pkg::PosW'(fpos);
    r.value  = v;
    r.count  = olis_pkg::PosW'(count);
    r.last   = last;
    expected_q.push_back(r);
  endfunction

  function void note_input(logic [olis_pkg::KindW-1:0] kind,
                           logic signed [olis_pkg::ValW-1:0] val,
                           logic [olis_pkg::PosW-1:0] pos);
    int last_hit;
    case (kind)
      olis_pkg::OP_APPEND: begin
        if (count >= olis_pkg::DepthDefault) begin
          queue_result(olis_pkg::ST_FULL, 0, 0, 1'b1);
        end else begin
          store[count] = val;
          count++;
          queue_result(olis_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      olis_pkg::OP_INSERT: begin
        if (pos < 1 || pos > count + 1) begin
          queue_result(olis_pkg::ST_BADPOS, 0, 0, 1'b1);
        end else if (count >= olis_pkg::DepthDefault) begin
          queue_result(olis_pkg::ST_FULL, 0, 0, 1'b1);
        end else begin
          for (int i = int'(count); i >= int'(pos); i--) store[i] = store[i-1];
          store[pos-1] = val;
          count++;
          queue_result(olis_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      olis_pkg::OP_POP: begin
        if (count == 0) begin
          queue_result(olis_pkg::ST_EMPTY, 0, 0, 1'b1);
        end else begin
          count--;
          queue_result(olis_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      olis_pkg::OP_REMOVE: begin
        if (count == 0) begin
          queue_result(olis_pkg::ST_EMPTY, 0, 0, 1'b1);
        end else if (pos < 1 || pos > count) begin
          queue_result(olis_pkg::ST_BADPOS, 0, 0, 1'b1);
        end else begin
          for (int i = int'(pos); i < int'(count); i++) store[i-1] = store[i];
          count--;
          queue_result(olis_pkg::ST_OK, 0, 0, 1'b1);
        end
      end
      olis_pkg::OP_SEARCH: begin
        last_hit = -1;
        for (int i = 0; i < int'(count); i++) if (store[i] == val) last_hit = i;
        if (count == 0) begin
          queue_result(olis_pkg::ST_EMPTY, 0, 0, 1'b1);
        end else if (last_hit < 0) begin
          queue_result(olis_pkg::ST_NOTFOUND, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i <= last_hit; i++)
            if (store[i] == val) queue_result(olis_pkg::ST_OK, i + 1, 0, i == last_hit);
        end
      end
      olis_pkg::OP_READ: begin
        if (count == 0) begin
          queue_result(olis_pkg::ST_EMPTY, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < int'(count); i++)
            queue_result(olis_pkg::ST_OK, i + 1, store[i], i + 1 == int'(count));
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(olis_pkg::res_t got);
    olis_pkg::res_t exp_r;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d: unexpected beat status=%0d pos=%0d value=%0d count=%0d last=%0b",
                 mismatches, got.status, got.fpos, got.value, got.count, got.last);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.status !== exp_r.status || got.fpos !== exp_r.fpos || got.value !== exp_r.value ||
        got.count !== exp_r.count || got.last !== exp_r.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch %0d: expected status=%0d pos=%0d value=%0d count=%0d last=%0b",
                 mismatches, exp_r.status, exp_r.fpos, exp_r.value, exp_r.count, exp_r.last);
        $display("             got      status=%0d pos=%0d value=%0d count=%0d last=%0b",
                 got.status, got.fpos, got.value, got.count, got.last);
      end
    end
  endfunction
endclass

module tb_top;
  localparam int unsigned   Depth      = olis_pkg::DepthDefault;
  localparam int unsigned   CycleLimit = 400_000;
  localparam logic [2:0]    KindSpare6 = 3'd6;
  localparam logic [2:0]    KindSpare7 = 3'd7;

  logic                               clk        = 1'b0;
  logic                               rst_n      = 1'b0;
  logic                               in_valid   = 1'b0;
  logic [olis_pkg::KindW-1:0]         kind       = '0;
  logic signed [olis_pkg::ValW-1:0]   item_value = '0;
  logic [olis_pkg::PosW-1:0]          position   = '0;
  logic                               out_ready  = 1'b0;
  wire                                in_ready;
  wire                                out_valid;
  wire [2:0]                          status;
  wire [olis_pkg::PosW-1:0]           found_position;
  wire signed [olis_pkg::ValW-1:0]    element_value;
  wire [olis_pkg::PosW-1:0]           element_count;
  wire                                last_result;

  int unsigned              send_gap_pct = 0;
  int unsigned              stall_pct    = 0;
  int unsigned              cycle_count  = 0;
  bit                       growing      = 1'b1;
  list_scoreboard           sb;

  ordered_list_insert_delete_search #(.DEPTH(Depth)) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .kind_i           (kind),
    .item_value_i     (item_value),
    .position_i       (position),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .status_o         (status),
    .found_position_o (found_position),
    .element_value_o  (element_value),
    .element_count_o  (element_count),
    .last_result_o    (last_result)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic bit chance(int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  always @(posedge clk) begin : result_side
    olis_pkg::res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = olis_pkg::status_e'(status);
      got.fpos   = found_position;
      got.value  = element_value;
      got.count  = element_count;
      got.last   = last_result;
      sb.check_result(got);
    end
    out_ready <= !chance(stall_pct);
  end

  task automatic send_op(input logic [olis_pkg::KindW-1:0] k,
                         input logic signed [olis_pkg::ValW-1:0] v,
                         input logic [olis_pkg::PosW-1:0] p);
    if (chance(send_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (chance(send_gap_pct)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    item_value <= v;
    position   <= p;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, v, p);
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned gap,
                           input int unsigned stall);
    int unsigned                      done_n;
    int unsigned                      r;
    int unsigned                      cnt;
    logic [olis_pkg::KindW-1:0]       k;
    logic signed [olis_pkg::ValW-1:0] v;
    logic [olis_pkg::PosW-1:0]        p;
    send_gap_pct = gap;
    stall_pct    = stall;
    done_n       = 0;
    while (done_n < n_items) begin
      cnt = sb.count;
      if (cnt == Depth && $urandom_range(3, 0) == 0) growing = 1'b0;
      if (cnt == 0 && $urandom_range(1, 0) == 0) growing = 1'b1;
      r = $urandom_range(99, 0);
      if (r < 3)
        k = $urandom_range(1, 0) ? KindSpare6 : KindSpare7;
      else if (growing)
        k = r < 35 ? olis_pkg::OP_APPEND : r < 65 ? olis_pkg::OP_INSERT :
            r < 70 ? olis_pkg::OP_POP : r < 78 ? olis_pkg::OP_REMOVE :
            r < 90 ? olis_pkg::OP_SEARCH : olis_pkg::OP_READ;
      else
        k = r < 8 ? olis_pkg::OP_APPEND : r < 13 ? olis_pkg::OP_INSERT :
            r < 40 ? olis_pkg::OP_POP : r < 70 ? olis_pkg::OP_REMOVE :
            r < 85 ? olis_pkg::OP_SEARCH : olis_pkg::OP_READ;
      if ($urandom_range(9, 0) < 6) begin
        case ($urandom_range(5, 0))
          0:       v = '0;
          1:       v = -32'sd1;
          2:       v = 32'sh8000_0000;
          3:       v = 32'sh7fff_ffff;
          4:       v = 32'sd5;
          default: v = 32'sd17;
        endcase
      end else begin
        v = $signed($urandom);
      end
      r = $urandom_range(9, 0);
      if (r < 8)       p = olis_pkg::PosW'($urandom_range(cnt + 1, 1));
      else if (r == 8) p = '0;
      else             p = olis_pkg::PosW'($urandom_range(127, 0));
      send_op(k, v, p);
      if (k <= olis_pkg::OP_READ) done_n++;
    end
  endtask

  initial begin
    sb = new;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(olis_pkg::OP_READ,   '0, 7'd0);
    send_op(olis_pkg::OP_SEARCH, 32'sd5, 7'd0);
    send_op(olis_pkg::OP_POP,    '0, 7'd0);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd0);
    send_op(olis_pkg::OP_INSERT, 32'sd9, 7'd0);
    send_op(olis_pkg::OP_INSERT, 32'sd9, 7'd2);
    send_op(olis_pkg::OP_INSERT, 32'sh8000_0000, 7'd1);
    send_op(olis_pkg::OP_APPEND, 32'sh7fff_ffff, 7'd0);
    send_op(olis_pkg::OP_INSERT, '0, 7'd3);
    send_op(olis_pkg::OP_INSERT, -32'sd1, 7'd1);
    send_op(olis_pkg::OP_APPEND, 32'sh7fff_ffff, 7'd127);
    send_op(KindSpare6, 32'sd1, 7'd1);
    send_op(KindSpare7, 32'sd1, 7'd1);
    send_op(olis_pkg::OP_SEARCH, 32'sh7fff_ffff, 7'd0);
    send_op(olis_pkg::OP_SEARCH, 32'sd12345, 7'd0);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd0);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd6);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd127);
    send_op(olis_pkg::OP_INSERT, 32'sd3, 7'd127);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd5);
    send_op(olis_pkg::OP_REMOVE, '0, 7'd1);
    send_op(olis_pkg::OP_READ,   '0, 7'd0);
    send_op(olis_pkg::OP_POP,    '0, 7'd0);
    send_op(olis_pkg::OP_READ,   '0, 7'd0);

    run_phase(49, 0, 0);
    run_phase(49, 86, 0);
    run_phase(49, 0, 86);
    run_phase(49, 12, 12);

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
rtl/olis_pkg.sv
rtl/olis_front.sv
rtl/olis_queue.sv
rtl/olis_back.sv
rtl/ordered_list_insert_delete_search.sv
bench/tb_top.sv
